// ===== hw/rtl/uer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Phase encoding, request and register codes, and fixed-point constants.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned TICK_W    = 17;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned DIST_W    = 19;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FACTOR_W  = 11;
  localparam int unsigned PROD_W    = TICK_W + FACTOR_W;

  localparam logic [TICK_W-1:0]    TRIG_LOW_TICKS  = TICK_W'(5);
  localparam logic [TICK_W-1:0]    TRIG_HIGH_TICKS = TICK_W'(10);
  localparam logic [FACTOR_W-1:0]  Q8_FACTOR       = FACTOR_W'(1124);
  localparam logic [PROD_W-1:0]    Q8_ROUND        = PROD_W'(128);

  localparam logic [TIMEOUT_W-1:0] RISE_TIMEOUT_RST = TIMEOUT_W'(50000);
  localparam logic [TIMEOUT_W-1:0] FALL_TIMEOUT_RST = TIMEOUT_W'(50000);
  localparam logic [DIST_W-1:0]    STOP_THRESH_RST  = DIST_W'(7803);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TLOW  = 3'd1,
    PH_THIGH = 3'd2,
    PH_RISE  = 3'd3,
    PH_FALL  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SINGLE  = 2'd1,
    REQ_NEAREST = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_TIMEOUT = 2'd0,
    CFG_FALL_TIMEOUT = 2'd1,
    CFG_STOP_THRESH  = 2'd2
  } cfg_idx_t;

endpackage

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: two-sensor ultrasonic ranging controller
// Triggers front/rear sensors, times echo widths and reports distance in Q8 cm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one word per microsecond tick, with the
//   start request, sensor select and both sampled echo levels.
//   Output channel (out_valid/out_stall): one word per accepted input word,
//   carrying the trigger levels, busy/done flags and any distance report.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//   index 0 rise timeout, 1 fall timeout, 2 stop threshold. Other indexes are
//   dropped. Write only while no measurement runs.
// Timing: the result word is registered and appears in the cycle after its
//   input word is accepted; one word per cycle while out_stall is low. One
//   combinational path (one 17x11 multiply, then compares) runs from the
//   input word and the measurement state to the result register.
// Reset: the configuration and state registers return to their reset values,
//   the sequencer goes idle and the output register empties.
// Stall: while a result word waits under out_stall, in_stall is raised and
//   the state holds; the input side resumes in the cycle the word is taken.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic                        sensor_sel,
  input  logic                        echo_front,
  input  logic                        echo_rear,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        trig_front,
  output logic                        trig_rear,
  output logic                        busy_res,
  output logic                        done_res,
  output logic                        range_valid,
  output logic [uer_pkg::DIST_W-1:0]  distance_q8,
  output logic                        nearest_is_rear,
  output logic                        obstacle,
  // config channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import uer_pkg::*;

  // configuration
  logic [TIMEOUT_W-1:0] rise_timeout;
  logic [TIMEOUT_W-1:0] fall_timeout;
  logic [DIST_W-1:0]    stop_threshold;

  // measurement state
  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic                current_sensor, current_sensor_next;
  logic                nearest_mode, nearest_mode_next;
  logic [DIST_W-1:0]   first_distance, first_distance_next;
  logic                first_valid, first_valid_next;

  logic                in_accept;
  logic                echo;
  logic [TICK_W-1:0]   tick_inc;
  logic [PROD_W-1:0]   scaled;
  logic [DIST_W-1:0]   fin_dist;
  logic                finished;
  logic                fin_valid;
  logic                chain_rear;

  // result word, combinational
  logic                trig;
  logic                res_done, res_valid, res_rear, res_obst;
  logic [DIST_W-1:0]   res_dist;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign echo     = current_sensor ? echo_rear : echo_front;
  assign tick_inc = tick_count + TICK_W'(1);
  assign scaled   = (PROD_W'(tick_inc) * PROD_W'(Q8_FACTOR)) + Q8_ROUND;
  assign fin_dist = scaled[DIST_W+7:8];

  // wait outcomes for the sensor in flight
  always_comb begin
    finished  = 1'b0;
    fin_valid = 1'b0;
    if (phase == PH_RISE) begin
      finished = !echo && (tick_inc >= TICK_W'(rise_timeout));
    end else if (phase == PH_FALL) begin
      if (!echo) begin
        finished  = 1'b1;
        fin_valid = 1'b1;
      end else begin
        finished = tick_inc >= TICK_W'(fall_timeout);
      end
    end
  end

  // front half of a nearest measurement rolls over into the rear trigger
  assign chain_rear = nearest_mode && !current_sensor;

  // next state
  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    current_sensor_next = current_sensor;
    nearest_mode_next   = nearest_mode;
    first_distance_next = first_distance;
    first_valid_next    = first_valid;
    unique case (phase)
      PH_IDLE: begin
        if (req_type == REQ_SINGLE || req_type == REQ_NEAREST) begin
          nearest_mode_next   = (req_type == REQ_NEAREST);
          current_sensor_next = (req_type == REQ_NEAREST) ? 1'b0 : sensor_sel;
          phase_next          = PH_TLOW;
          tick_count_next     = TICK_W'(1);
        end
      end
      PH_TLOW: begin
        if (tick_count >= TRIG_LOW_TICKS) begin
          phase_next      = PH_THIGH;
          tick_count_next = TICK_W'(1);
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_THIGH: begin
        if (tick_count >= TRIG_HIGH_TICKS) begin
          phase_next      = PH_RISE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_RISE: begin
        if (echo) begin
          phase_next      = PH_FALL;
          tick_count_next = '0;
        end else if (!finished) begin
          tick_count_next = tick_inc;
        end
      end
      PH_FALL: begin
        if (!finished) begin
          tick_count_next = tick_inc;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    if (finished) begin
      if (chain_rear) begin
        first_distance_next = fin_valid ? fin_dist : '0;
        first_valid_next    = fin_valid;
        current_sensor_next = 1'b1;
        phase_next          = PH_TLOW;
        tick_count_next     = TICK_W'(1);
      end else begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    end
  end

  // result word
  always_comb begin
    trig      = 1'b0;
    res_done  = 1'b0;
    res_valid = 1'b0;
    res_dist  = '0;
    res_rear  = 1'b0;
    unique case (phase)
      PH_TLOW:  trig = tick_count >= TRIG_LOW_TICKS;
      PH_THIGH: trig = tick_count < TRIG_HIGH_TICKS;
      default:  trig = 1'b0;
    endcase
    if (finished && !chain_rear) begin
      res_done = 1'b1;
      if (nearest_mode) begin
        if (first_valid && fin_valid) begin
          res_valid = 1'b1;
          if (first_distance < fin_dist) begin
            res_dist = first_distance;
          end else begin
            res_dist = fin_dist;
            res_rear = 1'b1;
          end
        end else if (fin_valid) begin
          res_valid = 1'b1;
          res_dist  = fin_dist;
          res_rear  = 1'b1;
        end else if (first_valid) begin
          res_valid = 1'b1;
          res_dist  = first_distance;
        end
      end else if (fin_valid) begin
        res_valid = 1'b1;
        res_dist  = fin_dist;
        res_rear  = current_sensor;
      end
    end
    res_obst = res_valid && (res_dist <= stop_threshold);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_timeout   <= RISE_TIMEOUT_RST;
      fall_timeout   <= FALL_TIMEOUT_RST;
      stop_threshold <= STOP_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RISE_TIMEOUT: rise_timeout   <= cfg_data[TIMEOUT_W-1:0];
        CFG_FALL_TIMEOUT: fall_timeout   <= cfg_data[TIMEOUT_W-1:0];
        CFG_STOP_THRESH:  stop_threshold <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // measurement state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      current_sensor <= 1'b0;
      nearest_mode   <= 1'b0;
      first_distance <= '0;
      first_valid    <= 1'b0;
    end else if (in_accept) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      current_sensor <= current_sensor_next;
      nearest_mode   <= nearest_mode_next;
      first_distance <= first_distance_next;
      first_valid    <= first_valid_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      trig_front      <= trig && !current_sensor;
      trig_rear       <= trig && current_sensor;
      busy_res        <= phase_next != PH_IDLE;
      done_res        <= res_done;
      range_valid     <= res_valid;
      distance_q8     <= res_dist;
      nearest_is_rear <= res_rear;
      obstacle        <= res_obst;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("report while still busy");

  a_obst_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && obstacle |-> range_valid && done_res)
    else $error("obstacle without valid report");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_valid |-> distance_q8 == '0 && !nearest_is_rear)
    else $error("invalid report carries data");

  a_one_trig: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trig_front && trig_rear))
    else $error("both triggers driven");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (trig_front || trig_rear) |-> busy_res && !done_res)
    else $error("trigger outside a measurement");
`endif

endmodule

// ===== tb/tb_ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger: self-checking bench for the echo ranger
// Feeds microsecond tick words (requests plus shaped echo pulses for both
// sensors), predicts every result word from a local model of the sequencer
// and compares field by field, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int unsigned Q8_SCALE       = 1124;
  localparam logic [1:0]  REQ_SPARE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int          PHASE_WORDS    = 190;

  typedef struct packed {
    logic [1:0] req;
    logic       sel;
    logic       echo_f;
    logic       echo_r;
  } tick_t;

  typedef struct packed {
    logic              trig_f;
    logic              trig_r;
    logic              busy;
    logic              done;
    logic              ok;
    logic [DIST_W-1:0] distance;
    logic              rear;
    logic              obst;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [1:0]           req_type   = 2'd0;
  logic                 sensor_sel = 1'b0;
  logic                 echo_front = 1'b0;
  logic                 echo_rear  = 1'b0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic                 trig_front;
  logic                 trig_rear;
  logic                 busy_res;
  logic                 done_res;
  logic                 range_valid;
  logic [DIST_W-1:0]    distance_q8;
  logic                 nearest_is_rear;
  logic                 obstacle;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;

  ultrasonic_echo_ranger dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .sensor_sel     (sensor_sel),
    .echo_front     (echo_front),
    .echo_rear      (echo_rear),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trig_front     (trig_front),
    .trig_rear      (trig_rear),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .range_valid    (range_valid),
    .distance_q8    (distance_q8),
    .nearest_is_rear(nearest_is_rear),
    .obstacle       (obstacle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Local copy of the sequencer and its registers.
  phase_t              rng_phase    = PH_IDLE;
  logic [TICK_W-1:0]   rng_ticks    = '0;
  logic                rng_rear     = 1'b0;
  logic                rng_nearest  = 1'b0;
  logic [DIST_W-1:0]   rng_first_d  = '0;
  logic                rng_first_ok = 1'b0;
  logic [TIMEOUT_W-1:0] rng_rise    = RISE_TIMEOUT_RST;
  logic [TIMEOUT_W-1:0] rng_fall    = FALL_TIMEOUT_RST;
  logic [DIST_W-1:0]   rng_thr      = STOP_THRESH_RST;

  tick_t       tick_words[$];
  report_t     echo_reports[$];
  int          errors       = 0;
  int          words_queued = 0;
  int          words_seen   = 0;
  int          reports_done = 0;
  int          reports_ok   = 0;
  int          reports_obst = 0;
  int          reports_rear = 0;
  int          idle_cycles  = 0;
  int unsigned cyc          = 0;
  logic        in_took      = 1'b0;
  logic        cfg_took     = 1'b0;
  logic        calm;

  assign calm = ((cyc % 4096) >= 1200) && ((cyc % 4096) < 1600);

  function automatic report_t step_ranger(tick_t w);
    report_t           r;
    logic              echo, trig, fin, fin_ok;
    logic [DIST_W-1:0] fin_d;
    logic [TICK_W:0]   nxt;
    logic [31:0]       prod;
    r      = '0;
    trig   = 1'b0;
    fin    = 1'b0;
    fin_ok = 1'b0;
    fin_d  = '0;
    echo   = rng_rear ? w.echo_r : w.echo_f;
    nxt    = {1'b0, rng_ticks} + 1'b1;
    case (rng_phase)
      PH_IDLE: begin
        if (w.req == REQ_SINGLE || w.req == REQ_NEAREST) begin
          rng_nearest = (w.req == REQ_NEAREST);
          rng_rear    = (w.req == REQ_NEAREST) ? 1'b0 : w.sel;
          rng_phase   = PH_TLOW;
          rng_ticks   = TICK_W'(1);
        end
      end
      PH_TLOW: begin
        if (rng_ticks >= TRIG_LOW_TICKS) begin
          rng_phase = PH_THIGH;
          rng_ticks = TICK_W'(1);
          trig      = 1'b1;
        end else begin
          rng_ticks = rng_ticks + 1'b1;
        end
      end
      PH_THIGH: begin
        if (rng_ticks >= TRIG_HIGH_TICKS) begin
          rng_phase = PH_RISE;
          rng_ticks = '0;
        end else begin
          rng_ticks = rng_ticks + 1'b1;
          trig      = 1'b1;
        end
      end
      PH_RISE: begin
        if (echo) begin
          rng_phase = PH_FALL;
          rng_ticks = '0;
        end else if (nxt >= rng_rise) begin
          fin = 1'b1;
        end else begin
          rng_ticks = nxt[TICK_W-1:0];
        end
      end
      PH_FALL: begin
        if (!echo) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
          prod   = 32'(nxt) * Q8_SCALE + 32'd128;
          fin_d  = prod[DIST_W+7:8];
        end else if (nxt >= rng_fall) begin
          fin = 1'b1;
        end else begin
          rng_ticks = nxt[TICK_W-1:0];
        end
      end
      default: begin
        rng_phase = PH_IDLE;
        rng_ticks = '0;
      end
    endcase

    if (fin) begin
      if (rng_nearest && !rng_rear) begin
        // front done: keep its outcome and trigger the rear sensor
        rng_first_d  = fin_d;
        rng_first_ok = fin_ok;
        rng_rear     = 1'b1;
        rng_phase    = PH_TLOW;
        rng_ticks    = TICK_W'(1);
      end else begin
        if (rng_nearest) begin
          if (rng_first_ok && fin_ok) begin
            // ties go to the rear sensor
            if (rng_first_d < fin_d) begin
              r.distance = rng_first_d;
              r.rear     = 1'b0;
            end else begin
              r.distance = fin_d;
              r.rear     = 1'b1;
            end
            r.ok = 1'b1;
          end else if (fin_ok) begin
            r.distance = fin_d;
            r.rear     = 1'b1;
            r.ok       = 1'b1;
          end else if (rng_first_ok) begin
            r.distance = rng_first_d;
            r.rear     = 1'b0;
            r.ok       = 1'b1;
          end
        end else if (fin_ok) begin
          r.distance = fin_d;
          r.rear     = rng_rear;
          r.ok       = 1'b1;
        end
        r.done    = 1'b1;
        r.obst    = r.ok && (r.distance <= rng_thr);
        rng_phase = PH_IDLE;
        rng_ticks = '0;
      end
    end
    r.trig_f = trig && !rng_rear;
    r.trig_r = trig && rng_rear;
    r.busy   = (rng_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Input side: hold the word until taken, idle at random outside calm windows.
  always @(negedge clk) begin : drive_ticks
    tick_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tick_words.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
        w = tick_words.pop_front();
        in_valid   <= 1'b1;
        req_type   <= w.req;
        sensor_sel <= w.sel;
        echo_front <= w.echo_f;
        echo_rear  <= w.echo_r;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin : watch_ports
    report_t want, got;
    cyc <= cyc + 1;
    if (rst) begin
      in_took     <= 1'b0;
      cfg_took    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took  <= in_valid && !in_stall;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RISE_TIMEOUT: rng_rise = cfg_data[TIMEOUT_W-1:0];
          CFG_FALL_TIMEOUT: rng_fall = cfg_data[TIMEOUT_W-1:0];
          CFG_STOP_THRESH:  rng_thr  = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{trig_front, trig_rear, busy_res, done_res, range_valid, distance_q8,
                nearest_is_rear, obstacle};
        if (echo_reports.size() == 0) begin
          $error("result word with nothing outstanding");
          errors++;
        end else begin
          want = echo_reports.pop_front();
          words_seen++;
          check_field("trig_front", want.trig_f, got.trig_f);
          check_field("trig_rear", want.trig_r, got.trig_r);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("range_valid", want.ok, got.ok);
          check_field("distance_q8", want.distance, got.distance);
          check_field("nearest_is_rear", want.rear, got.rear);
          check_field("obstacle", want.obst, got.obst);
          if (want.done) reports_done++;
          if (want.ok) reports_ok++;
          if (want.obst) reports_obst++;
          if (want.ok && want.rear) reports_rear++;
        end
      end
      if (in_valid && !in_stall)
        echo_reports.push_back(step_ranger('{req_type, sensor_sel, echo_front, echo_rear}));
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("** ultrasonic_echo_ranger: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // Ticks from the sensor's first trigger-low tick to the tick that ends it.
  function automatic int measure_len(int d, int k);
    int rm, fm;
    rm = (rng_rise == 0) ? 1 : int'(rng_rise);
    fm = (rng_fall == 0) ? 1 : int'(rng_fall);
    if (d >= rm) return 16 + rm;
    if (k <= fm) return 17 + d + k;
    return 17 + d + fm;
  endfunction

  // Echo level at tick t of a sensor's measurement: noise under the trigger,
  // d low samples, k high samples, then low.
  function automatic logic echo_at(int t, int d, int k);
    if (t <= 16) return 1'($urandom_range(1));
    return (t >= 17 + d) && (t < 17 + d + k);
  endfunction

  task automatic queue_measure(logic [1:0] req, logic sel, int d0, int k0, int d1, int k1,
                               int stray_pct);
    int    len0, total, t;
    tick_t w;
    len0  = measure_len(d0, k0);
    total = (req == REQ_NEAREST) ? len0 - 1 + measure_len(d1, k1) : len0;
    for (t = 1; t <= total; t++) begin
      // requests while busy must be dropped
      if (t == 1) w.req = req;
      else if ($urandom_range(99) < stray_pct) w.req = 2'($urandom_range(1, 3));
      else w.req = REQ_TICK;
      w.sel    = (t == 1) ? sel : 1'($urandom_range(1));
      w.echo_f = 1'($urandom_range(1));
      w.echo_r = 1'($urandom_range(1));
      if (req == REQ_NEAREST) begin
        if (t <= len0) w.echo_f = echo_at(t, d0, k0);
        if (t >= len0) w.echo_r = echo_at(t - len0 + 1, d1, k1);
      end else if (sel) begin
        w.echo_r = echo_at(t, d0, k0);
      end else begin
        w.echo_f = echo_at(t, d0, k0);
      end
      tick_words.push_back(w);
      words_queued++;
    end
  endtask

  function automatic int pick_delay(int rm);
    if (rm <= 64 && $urandom_range(99) < 25) return $urandom_range(rm, rm + 2);
    return $urandom_range(0, (rm - 1 < 30) ? rm - 1 : 30);
  endfunction

  function automatic int pick_width(int fm);
    if (fm <= 64 && $urandom_range(99) < 25) return $urandom_range(fm + 1, fm + 3);
    return $urandom_range(1, (fm < 40) ? fm : 40);
  endfunction

  task automatic queue_random_measure();
    int         rm, fm, d0, k0, d1, k1, n, i;
    logic [1:0] req;
    tick_t      w;
    rm = (rng_rise == 0) ? 1 : int'(rng_rise);
    fm = (rng_fall == 0) ? 1 : int'(rng_fall);
    if ($urandom_range(99) < 5) begin
      // short burst of raw noise, may start a stray measurement
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        w.req    = ($urandom_range(9) < 7) ? REQ_TICK : 2'($urandom_range(1, 3));
        w.sel    = 1'($urandom_range(1));
        w.echo_f = 1'($urandom_range(1));
        w.echo_r = 1'($urandom_range(1));
        tick_words.push_back(w);
        words_queued++;
      end
    end else begin
      req = $urandom_range(1) ? REQ_NEAREST : REQ_SINGLE;
      d0  = pick_delay(rm);
      k0  = pick_width(fm);
      d1  = pick_delay(rm);
      k1  = ($urandom_range(99) < 15) ? k0 : pick_width(fm);
      queue_measure(req, 1'($urandom_range(1)), d0, k0, d1, k1, 5);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
        w.req    = $urandom_range(1) ? REQ_TICK : REQ_SPARE;
        w.sel    = 1'($urandom_range(1));
        w.echo_f = 1'($urandom_range(1));
        w.echo_r = 1'($urandom_range(1));
        tick_words.push_back(w);
        words_queued++;
      end
    end
  endtask

  // Wait for every word to come back; if the sequencer is still mid
  // measurement, feed toggling echo ticks until it returns to idle.
  task automatic drain_to_idle();
    tick_t w;
    bit    idle_now;
    int    i;
    idle_now = 1'b0;
    while (!idle_now) begin
      @(negedge clk);
      if (tick_words.size() == 0 && !in_valid && echo_reports.size() == 0) begin
        if (rng_phase == PH_IDLE) begin
          idle_now = 1'b1;
        end else begin
          for (i = 0; i < 8; i++) begin
            w.req    = REQ_TICK;
            w.sel    = 1'b0;
            w.echo_f = ~i[0];
            w.echo_r = ~i[0];
            tick_words.push_back(w);
            words_queued++;
          end
        end
      end
    end
  endtask

  initial begin : run_ranger
    int    p, start;
    tick_t w;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values, plain single measurements and idle requests
    queue_measure(REQ_SINGLE, 1'b0, 3, 10, 0, 0, 0);
    queue_measure(REQ_SINGLE, 1'b1, 0, 1, 0, 0, 0);
    w = '{REQ_SPARE, 1'b1, 1'b1, 1'b1};
    tick_words.push_back(w);
    w = '{REQ_TICK, 1'b0, 1'b0, 1'b1};
    tick_words.push_back(w);
    words_queued += 2;
    drain_to_idle();

    // short timeouts; threshold equals the distance of a 5 us echo
    write_reg(CFG_RISE_TIMEOUT, 32'd8);
    write_reg(CFG_FALL_TIMEOUT, 32'd12);
    write_reg(CFG_STOP_THRESH, 32'd22);
    queue_measure(REQ_SINGLE, 1'b0, 2, 5, 0, 0, 0);
    queue_measure(REQ_SINGLE, 1'b1, 1, 6, 0, 0, 30);
    queue_measure(REQ_NEAREST, 1'b0, 0, 4, 3, 9, 0);
    queue_measure(REQ_NEAREST, 1'b1, 2, 7, 4, 7, 0);
    queue_measure(REQ_NEAREST, 1'b0, 1, 9, 0, 3, 30);
    queue_measure(REQ_NEAREST, 1'b0, 8, 4, 1, 5, 0);
    queue_measure(REQ_NEAREST, 1'b1, 0, 5, 2, 13, 0);
    queue_measure(REQ_NEAREST, 1'b0, 9, 3, 1, 20, 0);
    queue_measure(REQ_SINGLE, 1'b1, 7, 12, 0, 0, 0);
    queue_measure(REQ_SINGLE, 1'b0, 0, 13, 0, 0, 0);
    drain_to_idle();

    // zero timeouts, unused index, data bits beyond each register
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    write_reg(CFG_RISE_TIMEOUT, 32'hA5C3_0000);
    write_reg(CFG_FALL_TIMEOUT, 32'h5A3C_0000);
    write_reg(CFG_STOP_THRESH, {13'h1ABC, 19'd287740});
    queue_measure(REQ_SINGLE, 1'b0, 0, 1, 0, 0, 0);
    queue_measure(REQ_SINGLE, 1'b1, 1, 1, 0, 0, 0);
    queue_measure(REQ_NEAREST, 1'b0, 0, 2, 0, 1, 0);
    drain_to_idle();

    // long echo under the widest timeouts
    write_reg(CFG_RISE_TIMEOUT, 32'd65535);
    write_reg(CFG_FALL_TIMEOUT, 32'd65535);
    queue_measure(REQ_SINGLE, 1'b0, 2, 300, 0, 0, 0);
    drain_to_idle();

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(CFG_RISE_TIMEOUT, 32'($urandom_range(1, 20)));
          write_reg(CFG_FALL_TIMEOUT, 32'($urandom_range(1, 30)));
          write_reg(CFG_STOP_THRESH, 32'($urandom_range(0, 200)));
        end
        1: begin
          write_reg(CFG_RISE_TIMEOUT, 32'd1);
          write_reg(CFG_FALL_TIMEOUT, 32'd1);
          write_reg(CFG_STOP_THRESH, 32'd0);
        end
        2: begin
          write_reg(CFG_RISE_TIMEOUT, 32'd0);
          write_reg(CFG_FALL_TIMEOUT, 32'd0);
          write_reg(CFG_STOP_THRESH, 32'd287740);
        end
        3: begin
          write_reg(CFG_RISE_TIMEOUT, 32'($urandom_range(5, 40)));
          write_reg(CFG_FALL_TIMEOUT, 32'($urandom_range(5, 40)));
          write_reg(CFG_STOP_THRESH, 32'($urandom_range(0, 180)));
        end
        default: begin
          write_reg(CFG_RISE_TIMEOUT, 32'd65535);
          write_reg(CFG_FALL_TIMEOUT, 32'd65535);
          write_reg(CFG_STOP_THRESH, 32'($urandom_range(0, 287740)));
        end
      endcase
      start = words_queued;
      while (words_queued - start < PHASE_WORDS) queue_random_measure();
      drain_to_idle();
    end

    // let any stray word show up
    repeat (8) @(posedge clk);
    #1;
    if (echo_reports.size() != 0) begin
      $error("%0d result words never arrived", echo_reports.size());
      errors++;
    end
    $display("checked %0d of %0d tick words, %0d distance reports", words_seen,
             words_queued, reports_done);
    $display("  %0d valid (%0d rear), %0d obstacle, %0d mismatches", reports_ok,
             reports_rear, reports_obst, errors);
    if (errors == 0) begin
      $display("** ultrasonic_echo_ranger: PASSED **");
    end else begin
      $display("** ultrasonic_echo_ranger: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/uer_pkg.sv
hw/rtl/ultrasonic_echo_ranger.sv
tb/tb_ultrasonic_echo_ranger.sv
